FILE: src/sde_pkg.sv
package sde_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int STD_BITS       = 16;
   localparam int COUNT_OUT_BITS = 11;
   localparam int REQ_DATA_BITS  = 16;
   localparam int RSP_DATA_BITS  = 32;

   typedef logic [2:0] dp_op_type;

   localparam dp_op_type OP_HOLD   = 3'd0;
   localparam dp_op_type OP_LOAD   = 3'd1;
   localparam dp_op_type OP_MULQ   = 3'd2;
   localparam dp_op_type OP_LOAD_S = 3'd3;
   localparam dp_op_type OP_MULS   = 3'd4;
   localparam dp_op_type OP_DIV    = 3'd5;
   localparam dp_op_type OP_SQRT   = 3'd6;
   localparam dp_op_type OP_EMIT   = 3'd7;

   typedef struct packed {
      dp_op_type op;
      logic      first;
      logic      accept;
   } dp_cmd_type;

   typedef struct packed {
      logic set_close;
      logic rsp_busy;
   } dp_status_type;

endpackage

FILE: src/sde_ctrl.sv
module sde_ctrl #(
   parameter int MAX_ITEMS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  sde_pkg::dp_status_type status,
   output sde_pkg::dp_cmd_type    cmd
);
   import sde_pkg::*;

   localparam int CW  = $clog2(MAX_ITEMS + 1);
   localparam int SW  = SAMPLE_BITS + CW;
   localparam int DW  = 2 * SAMPLE_BITS + 2 * CW - 2;
   localparam int CTW = $clog2(DW);

   localparam logic [CTW-1:0] MULQ_LAST = CTW'(CW - 1);
   localparam logic [CTW-1:0] MULS_LAST = CTW'(SW - 1);
   localparam logic [CTW-1:0] DIV_LAST  = CTW'(DW - 1);
   localparam logic [CTW-1:0] SQRT_LAST = CTW'(SAMPLE_BITS - 1);

   localparam logic [3:0] ST_ACCUM  = 4'd0;
   localparam logic [3:0] ST_LOAD   = 4'd1;
   localparam logic [3:0] ST_MULQ   = 4'd2;
   localparam logic [3:0] ST_LOAD_S = 4'd3;
   localparam logic [3:0] ST_MULS   = 4'd4;
   localparam logic [3:0] ST_DIV1   = 4'd5;
   localparam logic [3:0] ST_DIV2   = 4'd6;
   localparam logic [3:0] ST_SQRT   = 4'd7;
   localparam logic [3:0] ST_EMIT   = 4'd8;

   logic [3:0]     state_ff, state_in;
   logic [CTW-1:0] step_ff, step_in;
   logic           first_ff, first_in;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      first_in   = 1'b0;
      req_tready = 1'b0;
      cmd.op     = OP_HOLD;
      cmd.first  = first_ff;
      cmd.accept = 1'b0;
      unique case (state_ff)
         ST_ACCUM: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
            if (req_tvalid && status.set_close) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.op   = OP_LOAD;
            state_in = ST_MULQ;
            step_in  = MULQ_LAST;
         end
         ST_MULQ: begin
            cmd.op = OP_MULQ;
            if (step_ff == '0) begin
               state_in = ST_LOAD_S;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_LOAD_S: begin
            cmd.op   = OP_LOAD_S;
            state_in = ST_MULS;
            step_in  = MULS_LAST;
         end
         ST_MULS: begin
            cmd.op = OP_MULS;
            if (step_ff == '0) begin
               state_in = ST_DIV1;
               step_in  = DIV_LAST;
               first_in = 1'b1;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_DIV1: begin
            cmd.op = OP_DIV;
            if (step_ff == '0) begin
               state_in = ST_DIV2;
               step_in  = DIV_LAST;
               first_in = 1'b1;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_DIV2: begin
            cmd.op = OP_DIV;
            if (step_ff == '0) begin
               state_in = ST_SQRT;
               step_in  = SQRT_LAST;
               first_in = 1'b1;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_SQRT: begin
            cmd.op = OP_SQRT;
            if (step_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            // Wait here only while the previous result is still unclaimed.
            if (!status.rsp_busy) begin
               cmd.op   = OP_EMIT;
               state_in = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
         step_ff  <= '0;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         first_ff <= first_in;
      end
   end

endmodule

FILE: src/sde_datapath.sv
module sde_datapath #(
   parameter int MAX_ITEMS = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sde_pkg::dp_cmd_type                   cmd,
   input  logic [sde_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   input  logic                                  req_tlast,
   input  logic                                  rsp_tready,
   output sde_pkg::dp_status_type                status,
   output logic                                  rsp_tvalid,
   output logic [sde_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   output logic                                  rsp_tuser
);
   import sde_pkg::*;

   localparam int SB = SAMPLE_BITS;
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int SW = SB + CW;
   localparam int QW = 2 * SB + CW - 1;
   localparam int DW = 2 * SB + 2 * CW - 2;
   localparam int VW = 2 * SB;
   localparam int PADW = RSP_DATA_BITS - COUNT_OUT_BITS - STD_BITS;

   // Accumulators for the open set.
   logic signed [SW-1:0] sum_ff, sum_in;
   logic [QW-1:0]        sq_ff, sq_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 long_ff, long_in;

   // Closing arithmetic: shift-add multiply, restoring divide, digit sqrt.
   logic [CW-1:0]        n_ff, n_in;
   logic [DW-1:0]        prod_ff, prod_in;
   logic [DW-1:0]        mcand_ff, mcand_in;
   logic [SW-1:0]        mplier_ff, mplier_in;
   logic [CW-1:0]        drem_ff, drem_in;
   logic [SB:0]          srem_ff, srem_in;
   logic [SB-1:0]        root_ff, root_in;

   logic                 out_valid_ff, out_valid_in;
   logic [STD_BITS-1:0]  out_std_ff, out_std_in;
   logic [COUNT_OUT_BITS-1:0] out_cnt_ff, out_cnt_in;
   logic                 out_long_ff, out_long_in;

   logic signed [SB-1:0]   sample;
   logic signed [2*SB-1:0] square;
   logic                   full;
   logic [SW-1:0]          sum_abs;
   logic [CW-1:0]          drem_prev;
   logic [CW:0]            drem_t, drem_diff;
   logic                   dge;
   logic [SB:0]            srem_prev;
   logic [SB-1:0]          root_prev;
   logic [SB+2:0]          srem_t, strial, srem_diff;
   logic                   sge;
   logic [CW+COUNT_OUT_BITS-1:0] cnt_wide;

   assign sample  = req_tdata[SB-1:0];
   assign square  = sample * sample;
   assign full    = (cnt_ff == CW'(MAX_ITEMS - 1));
   assign sum_abs = sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);

   assign drem_prev = cmd.first ? '0 : drem_ff;
   assign drem_t    = {drem_prev, prod_ff[DW-1]};
   assign drem_diff = drem_t - {1'b0, n_ff};
   assign dge       = (drem_t >= {1'b0, n_ff});

   assign srem_prev = cmd.first ? '0 : srem_ff;
   assign root_prev = cmd.first ? '0 : root_ff;
   assign srem_t    = {srem_prev, prod_ff[VW-1:VW-2]};
   assign strial    = {1'b0, root_prev, 2'b01};
   assign srem_diff = srem_t - strial;
   assign sge       = (srem_t >= strial);

   assign cnt_wide = {{COUNT_OUT_BITS{1'b0}}, n_ff};

   always_comb begin
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      cnt_in       = cnt_ff;
      long_in      = long_ff;
      n_in         = n_ff;
      prod_in      = prod_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      drem_in      = drem_ff;
      srem_in      = srem_ff;
      root_in      = root_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;
      out_std_in   = out_std_ff;
      out_cnt_in   = out_cnt_ff;
      out_long_in  = out_long_ff;

      if (cmd.accept) begin
         sum_in  = sum_ff + SW'(sample);
         sq_in   = sq_ff + QW'(unsigned'(square));
         cnt_in  = cnt_ff + 1'b1;
         long_in = full & ~req_tlast;
      end

      unique case (cmd.op)
         OP_HOLD: begin
         end
         OP_LOAD: begin
            prod_in   = '0;
            mcand_in  = DW'(sq_ff);
            mplier_in = SW'(cnt_ff);
            n_in      = cnt_ff;
         end
         OP_MULQ: begin
            if (mplier_ff[0]) begin
               prod_in = prod_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[DW-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[SW-1:1]};
         end
         OP_LOAD_S: begin
            mcand_in  = DW'(sum_abs);
            mplier_in = sum_abs;
            sum_in    = '0;
            sq_in     = '0;
            cnt_in    = '0;
         end
         OP_MULS: begin
            // n*Q never falls below S*S, so the running difference never goes negative.
            if (mplier_ff[0]) begin
               prod_in = prod_ff - mcand_ff;
            end
            mcand_in  = {mcand_ff[DW-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[SW-1:1]};
         end
         OP_DIV: begin
            drem_in = dge ? drem_diff[CW-1:0] : drem_t[CW-1:0];
            prod_in = {prod_ff[DW-2:0], dge};
         end
         OP_SQRT: begin
            srem_in = sge ? srem_diff[SB:0] : srem_t[SB:0];
            root_in = {root_prev[SB-2:0], sge};
            prod_in = {prod_ff[DW-3:0], 2'b00};
         end
         OP_EMIT: begin
            out_valid_in = 1'b1;
            out_std_in   = root_ff;
            out_cnt_in   = cnt_wide[COUNT_OUT_BITS-1:0];
            out_long_in  = long_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         sq_ff        <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      long_ff     <= long_in;
      n_ff        <= n_in;
      prod_ff     <= prod_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      drem_ff     <= drem_in;
      srem_ff     <= srem_in;
      root_ff     <= root_in;
      out_std_ff  <= out_std_in;
      out_cnt_ff  <= out_cnt_in;
      out_long_ff <= out_long_in;
   end

   assign status.set_close = req_tlast | full;
   assign status.rsp_busy  = out_valid_ff & ~rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{PADW{1'b0}}, out_cnt_ff, out_std_ff};
   assign rsp_tuser  = out_long_ff;

endmodule

FILE: src/standard_deviation_engine_top.sv
// Population standard deviation of signed fixed-point samples. Samples stream in one beat
// per cycle on req_ while the block accumulates (tlast closes a set); a set also closes by
// itself at MAX_ITEMS samples, and then rsp_tuser is set unless that sample also carried
// tlast. After a set closes the block takes no samples while one shared shift-and-add unit
// forms n*Q - S*S, divides it twice by n and takes the floored square root, one bit or digit
// per cycle. The result waits in an output register, so sampling of the next set resumes
// while it is unclaimed; only a second closing set waits for it.
module standard_deviation_engine_top #(
   parameter int MAX_ITEMS = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [sde_pkg::REQ_DATA_BITS-1:0]     req_tdata,  // [15:0] sample
   input  logic                                  req_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [sde_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,  // [15:0] std_dev, [26:16] item_count
   output logic                                  rsp_tuser   // [0] set_too_long
);
   import sde_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   sde_ctrl #(
      .MAX_ITEMS(MAX_ITEMS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   sde_datapath #(
      .MAX_ITEMS(MAX_ITEMS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tready(rsp_tready),
      .status    (status),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

FILE: src/sde_checker.sv
module sde_checker #(
   parameter int MAX_ITEMS = 1024
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic                                  req_tlast,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [sde_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   input logic                                  rsp_tuser
);
   import sde_pkg::*;

   localparam logic [COUNT_OUT_BITS-1:0] MAX_LOW = COUNT_OUT_BITS'(MAX_ITEMS);

   // Reset leaves no result pending.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat pending after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // A closing beat starts the back end, which takes no samples.
   a_close_stalls: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("sample taken right after a closing beat");

   // A set closed by length always holds MAX_ITEMS samples.
   a_long_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[26:16] == MAX_LOW)
      else $error("too-long result with wrong item count");

   // No more than half of full scale can be the deviation.
   a_std_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15] == 1'b0 || rsp_tdata[14:0] == 15'd0)
      else $error("deviation out of range");

endmodule

bind standard_deviation_engine_top sde_checker #(
   .MAX_ITEMS(MAX_ITEMS)
) u_sde_checker (.*);

FILE: tb/standard_deviation_engine_top_tb.sv
typedef struct packed {
   logic [15:0] std_dev;
   logic [10:0] item_count;
   logic        too_long;
} deviation_result_type;

// Tracks the open set of samples and queues the deviation that each closing set must produce.
class deviation_tracker;
   int unsigned          max_items;
   longint               code_sum;
   longint               square_sum;
   int unsigned          taken;
   deviation_result_type expected_results[$];
   int                   failures;
   int                   samples_seen;
   int                   sets_closed;
   int                   sets_cut;

   function new(int unsigned max_items_in);
      max_items    = max_items_in;
      code_sum     = 0;
      square_sum   = 0;
      taken        = 0;
      failures     = 0;
      samples_seen = 0;
      sets_closed  = 0;
      sets_cut     = 0;
   endfunction

   function longint floor_root(longint v);
      longint lo;
      longint hi;
      longint mid;
      lo = 0;
      hi = 65536;
      while (hi - lo > 1) begin
         mid = (lo + hi) / 2;
         if (mid * mid <= v) begin
            lo = mid;
         end else begin
            hi = mid;
         end
      end
      return lo;
   endfunction

   function void take_sample(logic [15:0] code, logic last);
      longint               x;
      longint               n;
      longint               spread;
      bit                   full;
      deviation_result_type r;
      x = longint'($signed(code));
      code_sum   += x;
      square_sum += x * x;
      taken++;
      samples_seen++;
      full = (taken >= max_items);
      if (!last && !full) return;
      // n*Q - S*S is never negative, so the division floors as intended.
      n = longint'(taken);
      spread = (n * square_sum - code_sum * code_sum) / (n * n);
      r.std_dev    = 16'(floor_root(spread));
      r.item_count = 11'(taken);
      r.too_long   = full && !last;
      expected_results.push_back(r);
      sets_closed++;
      if (r.too_long) sets_cut++;
      code_sum   = 0;
      square_sum = 0;
      taken      = 0;
   endfunction

   function void compare_result(logic [31:0] data, logic user);
      deviation_result_type want;
      if (expected_results.size() == 0) begin
         failures++;
         $display("%0t: result with nothing expected: std_dev=%0d item_count=%0d too_long=%0b",
                  $time, data[15:0], data[26:16], user);
         return;
      end
      want = expected_results.pop_front();
      if (data[15:0] !== want.std_dev) begin
         failures++;
         $display("%0t: std_dev expected %0d, got %0d", $time, want.std_dev, data[15:0]);
      end
      if (data[26:16] !== want.item_count) begin
         failures++;
         $display("%0t: item_count expected %0d, got %0d", $time, want.item_count, data[26:16]);
      end
      if (user !== want.too_long) begin
         failures++;
         $display("%0t: set_too_long expected %0b, got %0b", $time, want.too_long, user);
      end
   endfunction
endclass

module standard_deviation_engine_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_ITEMS    = 1024;
   localparam int RANDOM_ITEMS = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;  // [15:0] sample
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;       // [15:0] std_dev, [26:16] item_count
   logic        rsp_tuser;       // [0] set_too_long

   deviation_tracker sb = new(MAX_ITEMS);
   bit send_quiet = 1'b0;

   standard_deviation_engine_top #(.MAX_ITEMS(MAX_ITEMS)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Valid is dropped only when a gap follows, so back-to-back beats keep it high.
   task automatic send_sample(input logic [15:0] code, input logic last);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= code;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.take_sample(code, last);
   endtask

   function automatic logic [15:0] random_code();
      unique case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'(int'($urandom_range(0, 511)) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int          sent;
      int          len;
      bit          paused;
      logic [15:0] mixed [4];
      mixed = '{16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Single-sample sets at both extremes, the widest possible pair, an all-zero set and two mixed-sign sets.
      send_sample(16'h8000, 1'b1);
      send_sample(16'h7FFF, 1'b1);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h8000, 1'b1);
      for (int i = 0; i < 3; i++) send_sample(16'h0000, i == 2);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h0001, 1'b0);
      send_sample(16'hFF00, 1'b0);
      send_sample(16'h0100, 1'b1);
      for (int i = 0; i < 4; i++) send_sample(mixed[i], i == 3);

      // A full set with no tlast closes by itself and is flagged; the sums hit their extremes.
      send_quiet = 1'b1;
      for (int i = 0; i < MAX_ITEMS; i++) send_sample(16'h8000, 1'b0);
      // A full set whose final sample also carries tlast is not flagged.
      for (int i = 0; i < MAX_ITEMS; i++) begin
         send_sample((i % 2) ? 16'h7FFF : 16'h8000, i == MAX_ITEMS - 1);
      end

      sent = 0;
      paused = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 12);
         send_quiet = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < len; i++) send_sample(random_code(), i == len - 1);
         sent += len;
         if (!paused && sent >= RANDOM_ITEMS / 2) begin
            paused = 1'b1;
            req_tvalid <= 1'b0;
            while (sb.expected_results.size() != 0) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;

      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);

      $display("Covered %0d samples in %0d sets, %0d of them closed at the %0d-sample limit.",
               sb.samples_seen, sb.sets_closed, sb.sets_cut, MAX_ITEMS);
      if (sb.failures == 0 && sb.expected_results.size() == 0) begin
         $display("PASS standard_deviation_engine_top");
      end else begin
         $display("FAIL standard_deviation_engine_top");
      end
      $finish;
   end

   initial begin
      int  gap;
      int  received;
      bit  quiet;
      received = 0;
      quiet = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (received % 16 == 0) quiet = ($urandom_range(0, 2) == 0);
         gap = quiet ? 0 : $urandom_range(0, 10);
         // One long hold-off so that a finished result blocks the next closing set.
         if (received == 9) gap = 3000;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.compare_result(rsp_tdata, rsp_tuser);
         received++;
      end
   end

   initial begin
      #20ms;
      $display("FAIL standard_deviation_engine_top");
      $finish;
   end

endmodule

FILE: sim.f
src/sde_pkg.sv
src/sde_ctrl.sv
src/sde_datapath.sv
src/standard_deviation_engine_top.sv
src/sde_checker.sv
tb/standard_deviation_engine_top_tb.sv
